// File: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int PRIO_W    = 8;
    localparam int INFO_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 5;
    localparam int CAP_W     = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(2);

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [INFO_W-1:0] info;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/spq_if.sv
`default_nettype none

interface spq_in_if;
    import spq_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [PRIO_W-1:0] new_prio;
    logic [INFO_W-1:0] new_info;

    modport source (output valid, output operation, output new_prio, output new_info,
                    input ready);
    modport sink   (input valid, input operation, input new_prio, input new_info,
                    output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;

    logic                valid;
    logic                ready;
    logic [PRIO_W-1:0]   out_prio;
    logic [INFO_W-1:0]   out_info;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;

    modport source (output valid, output out_prio, output out_info, output status,
                    output count, input ready);
    modport sink   (input valid, input out_prio, input out_info, input status,
                    input count, output ready);
endinterface

`default_nettype wire

// File: rtl/sorted_priority_queue_top.sv
// Channel   Direction  Handshake      Word
// req       in         valid/ready    operation, new_prio, new_info
// rsp       out        valid/ready    out_prio, out_info, status, count
// cfg       in         cfg_we only    cfg_wdata = capacity
//
// Entries live in a circular one-read one-write RAM, head at the smallest priority.
// A remove reads the head, then emits; a rejected word or an insert into an empty queue
// goes straight to emit; any other insert first shifts up every stored entry with a
// larger priority: the insertion scan moves one entry per cycle through the RAM ports.
// Reset empties the queue at once and sets capacity to 16; no clearing pass.
// A new word is taken only while idle; a finished word waits in the result stage
// until rsp.ready, and the next request may be accepted meanwhile.
`default_nettype none

module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [spq_pkg::CAP_W-1:0] cfg_wdata,
    spq_in_if.sink                        req,
    spq_out_if.source                     rsp
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RM   = 5'b00010,
        S_CMP  = 5'b00100,
        S_PUT  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    state_t              state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [CAP_W-1:0]    cap_reg;
    logic                out_valid_reg, out_valid_next;

    logic [PRIO_W-1:0]   new_prio_reg, new_prio_next;
    logic [INFO_W-1:0]   new_info_reg, new_info_next;
    logic [PRIO_W-1:0]   res_prio_reg, res_prio_next;
    logic [INFO_W-1:0]   res_info_reg, res_info_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [INFO_W-1:0]   out_info_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    entry_t              mem_wdata;

    logic [AW-1:0]       ptr_dec, ptr_dec2, tail_dec, tail_inc, head_inc;
    logic [CAP_W-1:0]    cap_eff;
    logic                full, out_free, load_out;

    assign ptr_dec  = (ptr_reg == '0) ? LAST : ptr_reg - 1'b1;
    assign ptr_dec2 = (ptr_dec == '0) ? LAST : ptr_dec - 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST : tail_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == LAST) ? '0 : head_reg + 1'b1;

    // capacity zero acts as one; the built depth bounds it from above
    assign cap_eff  = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign full     = (occ_reg >= cap_eff) || (32'(occ_reg) >= DEPTH);
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid    = out_valid_reg;
    assign rsp.out_prio = out_prio_reg;
    assign rsp.out_info = out_info_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.count    = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        occ_next        = occ_reg;
        new_prio_next   = new_prio_reg;
        new_info_next   = new_info_reg;
        res_prio_next   = res_prio_reg;
        res_info_next   = res_info_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        load_out        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = '{prio: new_prio_reg, info: new_info_reg};
        mem_re          = 1'b0;
        mem_raddr       = ptr_dec;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    new_prio_next   = req.new_prio;
                    new_info_next   = req.new_info;
                    res_prio_next   = '0;
                    res_info_next   = '0;
                    res_status_next = ST_DONE;
                    if (req.operation == OP_REMOVE)
                    begin
                        if (occ_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg;
                            state_next = S_RM;
                        end
                    end
                    else if (full)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_EMIT;
                    end
                    else if (occ_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = tail_reg;
                        mem_wdata  = '{prio: req.new_prio, info: req.new_info};
                        occ_next   = occ_reg + 1'b1;
                        tail_next  = tail_inc;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        // scan backward from the tail, last entry first
                        mem_re     = 1'b1;
                        mem_raddr  = tail_dec;
                        ptr_next   = tail_reg;
                        idx_next   = occ_reg;
                        state_next = S_CMP;
                    end
                end
            end

            S_RM:
            begin
                res_prio_next = rdata_reg.prio;
                res_info_next = rdata_reg.info;
                head_next     = head_inc;
                occ_next      = occ_reg - 1'b1;
                state_next    = S_EMIT;
            end

            S_CMP:
            begin
                mem_we = 1'b1;
                if (rdata_reg.prio > new_prio_reg)
                begin
                    // shift the larger entry up one slot, fetch the next one down
                    mem_wdata = rdata_reg;
                    ptr_next  = ptr_dec;
                    if (idx_reg == CNT_W'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ptr_dec2;
                        idx_next   = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    occ_next   = occ_reg + 1'b1;
                    tail_next  = tail_inc;
                    state_next = S_EMIT;
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                occ_next   = occ_reg + 1'b1;
                tail_next  = tail_inc;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            occ_reg       <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            ptr_reg       <= ptr_next;
            idx_reg       <= idx_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        new_prio_reg   <= new_prio_next;
        new_info_reg   <= new_info_next;
        res_prio_reg   <= res_prio_next;
        res_info_reg   <= res_info_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            out_prio_reg   <= res_prio_reg;
            out_info_reg   <= res_info_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= occ_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire
